// File: hw/rtl/srls_pkg.sv
`timescale 1ns / 1ps

package srls_pkg;

    localparam int LOG_DEPTH = 128;
    localparam int ADDR_W    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int FILL_W    = $clog2(LOG_DEPTH + 1);
    localparam int SEQ_W     = 64;
    localparam int TYPE_W    = 8;
    localparam int PID_W     = 16;
    localparam int CNT_W     = 8;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_COUNT = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // datapath operation selected by the current control word
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_WRITE,
        OP_SCAN,
        OP_EMIT
    } t_uop;

    typedef enum logic [1:0] {
        COND_DISPATCH,
        COND_ALWAYS,
        COND_SCAN_END
    } t_cond;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_DONE
    } t_step;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_step jmp_t;
        t_step jmp_f;
    } t_uword;

    typedef struct packed {
        logic [1:0]        command;
        logic [TYPE_W-1:0] event_type;
        logic [PID_W-1:0]  process_id;
        logic [SEQ_W-1:0]  wanted_sequence;
    } t_in;

    typedef struct packed {
        logic              status;
        logic [TYPE_W-1:0] found_type;
        logic [PID_W-1:0]  found_pid;
        logic [CNT_W-1:0]  type_count;
        logic [SEQ_W-1:0]  upcoming_sequence;
    } t_out;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [TYPE_W-1:0] typ;
        logic [PID_W-1:0]  pid;
    } t_entry;

    typedef struct packed {
        logic start;
        t_cmd cmd;
        logic scan_end;
    } t_flags;

    typedef struct packed {
        t_uop op;
        logic busy;
    } t_ctrl;

endpackage

// File: hw/rtl/sequenced_ring_log_store.sv
`timescale 1ns / 1ps
// write: the entry is stored in the WRITE state, the result is registered in DONE, and a new start is taken in IDLE
// read / count: the entry walk reads one ring entry per cycle, newest first, over every filled
//   entry, and the result is registered once the walk ends; a read hit ends the walk early
// results are strobed for one cycle only; the receiver cannot stall
// reset clears position, fill count and sequence counter (to 1); the entry store needs no clearing
module sequenced_ring_log_store import srls_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_in  i_item,
    output logic o_busy,
    output logic o_valid,
    output t_out o_result
);

    t_flags w_flags;
    t_ctrl  w_ctrl;

    t_entry r_mem [LOG_DEPTH];
    t_entry r_rdata;

    logic [ADDR_W-1:0] r_wptr;
    logic [ADDR_W-1:0] r_rptr;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_idx;
    logic [SEQ_W-1:0]  r_seq;
    logic              r_pend;

    t_cmd              r_cmd;
    logic [TYPE_W-1:0] r_type;
    logic [PID_W-1:0]  r_pid;
    logic [SEQ_W-1:0]  r_want;

    logic              r_hit;
    logic [TYPE_W-1:0] r_ftype;
    logic [PID_W-1:0]  r_fpid;
    logic [CNT_W-1:0]  r_cnt;

    logic r_valid;
    t_out r_out;

    logic w_seq_match;
    logic w_type_match;
    logic w_accept;

    assign w_accept     = i_start && !w_ctrl.busy;
    assign w_seq_match  = r_pend && (r_cmd == CMD_READ) && (r_rdata.seq == r_want);
    assign w_type_match = r_pend && (r_cmd == CMD_COUNT) && (r_rdata.typ == r_type);

    assign w_flags.start    = i_start;
    assign w_flags.cmd      = t_cmd'(i_item.command);
    // stop on the newest hit, or once the last issued read has been checked
    assign w_flags.scan_end = w_seq_match || (!r_pend && (r_idx >= r_fill));

    srls_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    // entry store
    always_ff @(posedge i_clk) begin
        if (w_ctrl.op == OP_WRITE) begin
            r_mem[r_wptr] <= '{seq: r_seq, typ: r_type, pid: r_pid};
        end
        r_rdata <= r_mem[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_fill  <= '0;
            r_seq   <= SEQ_W'(1);
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (w_ctrl.op)
                OP_LOAD: begin
                    r_pend <= 1'b0;
                end
                OP_WRITE: begin
                    r_wptr <= (r_wptr == ADDR_W'(LOG_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
                    if (r_fill < FILL_W'(LOG_DEPTH)) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_seq <= r_seq + 1'b1;
                end
                OP_SCAN: begin
                    r_pend <= (r_idx < r_fill);
                end
                OP_EMIT: begin
                    r_valid <= 1'b1;
                end
                default: begin
                    r_pend <= 1'b0;
                end
            endcase
        end
    end

    // transaction latch, scan datapath and result register
    always_ff @(posedge i_clk) begin
        unique case (w_ctrl.op)
            OP_LOAD: begin
                if (w_accept) begin
                    r_cmd   <= t_cmd'(i_item.command);
                    r_type  <= i_item.event_type;
                    r_pid   <= i_item.process_id;
                    r_want  <= i_item.wanted_sequence;
                    r_idx   <= '0;
                    r_rptr  <= (r_wptr == '0) ? ADDR_W'(LOG_DEPTH - 1) : r_wptr - 1'b1;
                    r_hit   <= 1'b0;
                    r_ftype <= '0;
                    r_fpid  <= '0;
                    r_cnt   <= '0;
                end
            end
            OP_SCAN: begin
                // walk from newest to oldest
                if (r_idx < r_fill) begin
                    r_idx  <= r_idx + 1'b1;
                    r_rptr <= (r_rptr == '0) ? ADDR_W'(LOG_DEPTH - 1) : r_rptr - 1'b1;
                end
                if (w_seq_match) begin
                    r_hit   <= 1'b1;
                    r_ftype <= r_rdata.typ;
                    r_fpid  <= r_rdata.pid;
                end
                if (w_type_match && (r_cnt != {CNT_W{1'b1}})) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            OP_EMIT: begin
                r_out.status            <= (r_cmd == CMD_READ) && !r_hit;
                r_out.found_type        <= r_ftype;
                r_out.found_pid         <= r_fpid;
                r_out.type_count        <= r_cnt;
                r_out.upcoming_sequence <= r_seq;
            end
            default: begin
            end
        endcase
    end

    assign o_busy   = w_ctrl.busy;
    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

// File: hw/rtl/srls_seq.sv
`timescale 1ns / 1ps

module srls_seq import srls_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_ctrl  o_ctrl
);

    t_step  r_pc;
    t_step  n_pc;
    t_uword w_word;
    logic   w_taken;
    t_step  w_dispatch;

    // control store
    function automatic t_uword rom_word(input t_step pc);
        t_uword w;
        unique case (pc)
            ST_IDLE:  w = '{op: OP_LOAD,  cond: COND_DISPATCH, jmp_t: ST_IDLE, jmp_f: ST_IDLE};
            ST_WRITE: w = '{op: OP_WRITE, cond: COND_ALWAYS,   jmp_t: ST_DONE, jmp_f: ST_DONE};
            ST_SCAN:  w = '{op: OP_SCAN,  cond: COND_SCAN_END, jmp_t: ST_DONE, jmp_f: ST_SCAN};
            ST_DONE:  w = '{op: OP_EMIT,  cond: COND_ALWAYS,   jmp_t: ST_IDLE, jmp_f: ST_IDLE};
            default:  w = '{op: OP_LOAD,  cond: COND_ALWAYS,   jmp_t: ST_IDLE, jmp_f: ST_IDLE};
        endcase
        return w;
    endfunction

    always_comb begin
        w_word = rom_word(r_pc);
        unique case (i_flags.cmd)
            CMD_WRITE: w_dispatch = ST_WRITE;
            CMD_READ:  w_dispatch = ST_SCAN;
            CMD_COUNT: w_dispatch = ST_SCAN;
            CMD_NONE:  w_dispatch = ST_DONE;
            default:   w_dispatch = ST_DONE;
        endcase
        unique case (w_word.cond)
            COND_DISPATCH: w_taken = i_flags.start;
            COND_ALWAYS:   w_taken = 1'b1;
            COND_SCAN_END: w_taken = i_flags.scan_end;
            default:       w_taken = 1'b1;
        endcase
        if (w_word.cond == COND_DISPATCH) begin
            n_pc = w_taken ? w_dispatch : w_word.jmp_f;
        end else begin
            n_pc = w_taken ? w_word.jmp_t : w_word.jmp_f;
        end
        o_ctrl.op   = w_word.op;
        o_ctrl.busy = (r_pc != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// File: hw/rtl/srls_checker.sv
`timescale 1ns / 1ps

module srls_checker import srls_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input t_in  i_item,
    input logic o_busy,
    input logic o_valid,
    input t_out o_result
);

    // a result closes a transaction that was in progress
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy))
        else $error("result strobe without a transaction in progress");

    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result strobe while still busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted transaction did not raise busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status) |->
            (o_result.found_type == '0) && (o_result.found_pid == '0)
            && (o_result.type_count == '0))
        else $error("not-found result carries entry data");

endmodule

bind sequenced_ring_log_store srls_checker u_srls_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .i_item   (i_item),
    .o_busy   (o_busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import srls_pkg::*;

    localparam int NUM_RANDOM = 1530;
    localparam int BURST_TYPE = 8'h5a;

    // mirror of the log ring plus the replies still owed by the block
    class ring_log_model;
        t_entry            ring [LOG_DEPTH];
        int                wr_pos;
        int                fill;
        logic [SEQ_W-1:0]  seq_next;
        t_out              pending_replies [$];
        int                errors;

        function new();
            wr_pos   = 0;
            fill     = 0;
            seq_next = SEQ_W'(1);
            errors   = 0;
        endfunction

        task flag_mismatch(input string what);
            if (errors < 100) begin
                $display("[%0t] mismatch: %s", $time, what);
            end
            errors++;
        endtask

        function void apply_command(input t_in it);
            t_out r;
            int   slot;
            r = '0;
            case (it.command)
                CMD_WRITE: begin
                    ring[wr_pos] = '{seq: seq_next, typ: it.event_type, pid: it.process_id};
                    seq_next = seq_next + 1'b1;
                    wr_pos = (wr_pos + 1) % LOG_DEPTH;
                    if (fill < LOG_DEPTH) begin
                        fill++;
                    end
                end
                CMD_READ: begin
                    r.status = 1'b1;
                    // newest first, so the latest duplicate wins
                    for (int i = 0; i < fill; i++) begin
                        slot = (wr_pos + LOG_DEPTH - 1 - i) % LOG_DEPTH;
                        if (ring[slot].seq == it.wanted_sequence) begin
                            r.status     = 1'b0;
                            r.found_type = ring[slot].typ;
                            r.found_pid  = ring[slot].pid;
                            break;
                        end
                    end
                end
                CMD_COUNT: begin
                    for (int i = 0; i < fill; i++) begin
                        slot = (wr_pos + LOG_DEPTH - 1 - i) % LOG_DEPTH;
                        if (ring[slot].typ == it.event_type && r.type_count != 8'hff) begin
                            r.type_count = r.type_count + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            r.upcoming_sequence = seq_next;
            pending_replies.push_back(r);
        endfunction

        task match_reply(input t_out got);
            t_out want;
            if (pending_replies.size() == 0) begin
                flag_mismatch($sformatf("unexpected result %h", got));
            end else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status)
                    flag_mismatch($sformatf("status exp %h got %h", want.status, got.status));
                if (got.found_type !== want.found_type)
                    flag_mismatch($sformatf("found_type exp %h got %h",
                                            want.found_type, got.found_type));
                if (got.found_pid !== want.found_pid)
                    flag_mismatch($sformatf("found_pid exp %h got %h",
                                            want.found_pid, got.found_pid));
                if (got.type_count !== want.type_count)
                    flag_mismatch($sformatf("type_count exp %0d got %0d",
                                            want.type_count, got.type_count));
                if (got.upcoming_sequence !== want.upcoming_sequence)
                    flag_mismatch($sformatf("upcoming_sequence exp %h got %h",
                                            want.upcoming_sequence, got.upcoming_sequence));
            end
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_in  i_item  = '0;
    logic o_busy;
    logic o_valid;
    t_out o_result;

    ring_log_model log_model = new();
    int            idle_pct  = 0;

    sequenced_ring_log_store dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            log_model.match_reply(o_result);
        end
    end

    function automatic t_in make_cmd(input t_cmd cmd, input logic [TYPE_W-1:0] typ,
                                     input logic [PID_W-1:0] pid,
                                     input logic [SEQ_W-1:0] want);
        t_in it;
        it.command         = cmd;
        it.event_type      = typ;
        it.process_id      = pid;
        it.wanted_sequence = want;
        return it;
    endfunction

    // drive one transaction, holding start until the block takes it
    task automatic send_item(input t_in it);
        @(negedge i_clk);
        while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= it;
        do begin
            @(posedge i_clk);
        end while (o_busy);
        log_model.apply_command(it);
    endtask

    function automatic t_in make_random(input int n);
        t_in              it;
        int               pick;
        logic [SEQ_W-1:0] lo;
        it.command         = CMD_NONE;
        it.event_type      = TYPE_W'($urandom);
        it.process_id      = PID_W'($urandom);
        it.wanted_sequence = {$urandom, $urandom};
        pick = $urandom_range(99, 0);
        if (pick < 40) begin
            it.command = CMD_WRITE;
            // stretches of a single type push the count toward a full ring
            if ((n / 200) % 4 == 3)
                it.event_type = TYPE_W'(BURST_TYPE);
            else if ($urandom_range(1, 0) == 0)
                it.event_type = TYPE_W'($urandom_range(3, 0));
        end else if (pick < 70) begin
            it.command = CMD_READ;
            pick = $urandom_range(99, 0);
            if (pick < 60) begin
                // around the valid window, including just-overwritten entries
                lo = log_model.seq_next - SEQ_W'(log_model.fill) - SEQ_W'(4);
                it.wanted_sequence = lo + SEQ_W'($urandom_range(log_model.fill + 4, 0));
            end else if (pick < 80) begin
                it.wanted_sequence = log_model.seq_next - SEQ_W'($urandom_range(300, 0));
            end
        end else if (pick < 95) begin
            it.command = CMD_COUNT;
            if ($urandom_range(99, 0) < 70) begin
                pick = $urandom_range(4, 0);
                it.event_type = (pick == 4) ? TYPE_W'(BURST_TYPE) : TYPE_W'(pick);
            end
        end
        return it;
    endfunction

    initial begin
        int guard;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty ring, field extremes, hits, misses, counts, unused command
        send_item(make_cmd(CMD_NONE,  8'hff, 16'hffff, '1));
        send_item(make_cmd(CMD_READ,  8'h00, 16'h0000, 64'd1));
        send_item(make_cmd(CMD_COUNT, 8'h00, 16'h0000, 64'd0));
        send_item(make_cmd(CMD_WRITE, 8'h00, 16'h0000, 64'd0));
        send_item(make_cmd(CMD_WRITE, 8'hff, 16'hffff, '1));
        send_item(make_cmd(CMD_WRITE, 8'h00, 16'h1234, 64'd0));
        send_item(make_cmd(CMD_READ,  8'h00, 16'h0000, 64'd1));
        send_item(make_cmd(CMD_READ,  8'hff, 16'hffff, 64'd2));
        send_item(make_cmd(CMD_READ,  8'h00, 16'h0000, 64'd3));
        send_item(make_cmd(CMD_READ,  8'h00, 16'h0000, 64'd0));
        send_item(make_cmd(CMD_READ,  8'h00, 16'h0000, '1));
        send_item(make_cmd(CMD_READ,  8'h00, 16'h0000, 64'd4));
        send_item(make_cmd(CMD_COUNT, 8'h00, 16'h0000, 64'd0));
        send_item(make_cmd(CMD_COUNT, 8'hff, 16'hffff, '1));
        send_item(make_cmd(CMD_COUNT, 8'h07, 16'h0000, 64'd0));
        send_item(make_cmd(CMD_NONE,  8'h00, 16'h0000, 64'd0));
        send_item(make_cmd(CMD_WRITE, 8'h80, 16'h8000, 64'h8000_0000_0000_0000));
        send_item(make_cmd(CMD_COUNT, 8'h80, 16'h0000, 64'd0));
        send_item(make_cmd(CMD_READ,  8'h00, 16'h0000, 64'd4));

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n < NUM_RANDOM / 3)
                idle_pct = 28;
            else if (n < 2 * NUM_RANDOM / 3)
                idle_pct = 81;
            else
                idle_pct = 0;
            send_item(make_random(n));
        end

        @(negedge i_clk);
        i_start <= 1'b0;

        guard = 0;
        while (log_model.pending_replies.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (200) @(posedge i_clk);
        if (log_model.pending_replies.size() != 0) begin
            log_model.flag_mismatch($sformatf("%0d results never arrived",
                                              log_model.pending_replies.size()));
        end

        if (log_model.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
